// ===== src/text_console_char_writer_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the text console character writer
// Concurrent checks that compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_CHAR_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_CHAR_WRITER_ASSERT_SVH

`ifndef SYNTH
// Check that the condition implies the consequence in the same cycle
`define TCW_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: name");
// Check that the condition implies the consequence in the next cycle
`define TCW_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: name");
`else
`define TCW_ASSERT_IMPL(name, clk, rst_n, ante, cons)
`define TCW_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif

`endif

// ===== src/tcw_pkg.sv =====
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared constants of the text console character writer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tcw_pkg;

    // Default screen geometry and tab spacing
    localparam int COLUMNS_DEF  = 80;
    localparam int ROWS_DEF     = 25;
    localparam int TAB_STOP_DEF = 5;

    // Field widths
    localparam int CELL_W  = 16;
    localparam int BYTE_W  = 8;
    localparam int IDX_W   = 11;

    // Attribute after reset
    localparam logic [BYTE_W-1:0] COLOR_RESET = 8'd7;

    // Request types
    localparam logic REQ_PUT  = 1'b0;
    localparam logic REQ_READ = 1'b1;

    // Control characters
    localparam logic [BYTE_W-1:0] CH_BS    = 8'd8;
    localparam logic [BYTE_W-1:0] CH_TAB   = 8'd9;
    localparam logic [BYTE_W-1:0] CH_LF    = 8'd10;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'd13;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'd32;

endpackage

// ===== src/text_console_char_writer.sv =====
// ----------------------------------------------------------------------------
// text_console_char_writer
// Text-mode console: screen cell store, cursor, put and read requests.
// ----------------------------------------------------------------------------
// After reset the block clears the screen memory one cell a cycle and accepts
// no request meanwhile; color writes are taken at any time. Once running, a
// tab steps the cursor one cell per cycle until the next stop or the end of
// the screen. A put that finds the cursor past the last cell first scrolls:
// the read port and the write port of the screen memory copy one cell per
// cycle, then the bottom row is blanked one cell per cycle. Each request
// yields one result; a result that is not yet taken waits in the output
// register while the next request is worked on.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "text_console_char_writer_assert.svh"

module text_console_char_writer #(
    parameter int COLUMNS  = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS     = tcw_pkg::ROWS_DEF,
    parameter int TAB_STOP = tcw_pkg::TAB_STOP_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // request channel
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic                       i_req_type,
    input  logic [tcw_pkg::BYTE_W-1:0] i_char_code,
    input  logic [tcw_pkg::IDX_W-1:0]  i_cell_index,
    // result channel
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [tcw_pkg::BYTE_W-1:0] o_cell_char,
    output logic [tcw_pkg::BYTE_W-1:0] o_cell_attr,
    output logic [tcw_pkg::IDX_W-1:0]  o_cursor_pos,
    // color register write channel
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [tcw_pkg::BYTE_W-1:0] i_cfg_data
);
    import tcw_pkg::*;

    localparam int CELLS    = COLUMNS * ROWS;
    localparam int AW       = $clog2(CELLS);
    localparam int CW       = $clog2(CELLS + 1);
    localparam int COLW     = $clog2(COLUMNS);
    localparam int TW       = $clog2(TAB_STOP);
    localparam int CMT      = COLUMNS % TAB_STOP;
    localparam int RPH_LAST = ((ROWS - 1) * COLUMNS) % TAB_STOP;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_RDATA = 3'd2;
    localparam logic [2:0] S_MOVE  = 3'd3;
    localparam logic [2:0] S_BLANK = 3'd4;
    localparam logic [2:0] S_PUT   = 3'd5;
    localparam logic [2:0] S_TAB   = 3'd6;
    localparam logic [2:0] S_OUT   = 3'd7;

    // Control state
    logic [2:0]        r_state, n_state;
    logic [AW-1:0]     r_addr, n_addr;
    logic [CW-1:0]     r_cursor, n_cursor;
    logic [COLW-1:0]   r_col, n_col;      // cursor column
    logic [TW-1:0]     r_rph, n_rph;      // tab phase of the row start
    logic [TW-1:0]     r_tph, n_tph;      // tab phase of the cursor
    logic [BYTE_W-1:0] r_text_color;
    logic              r_out_valid, n_out_valid;

    // Payload state
    logic [BYTE_W-1:0] r_char, n_char;
    logic              r_idx_ok, n_idx_ok;
    logic [BYTE_W-1:0] r_res_char, n_res_char;
    logic [BYTE_W-1:0] r_res_attr, n_res_attr;
    logic [BYTE_W-1:0] r_out_char, n_out_char;
    logic [BYTE_W-1:0] r_out_attr, n_out_attr;
    logic [IDX_W-1:0]  r_out_cursor, n_out_cursor;

    // Memory port
    logic              w_we;
    logic [AW-1:0]     w_waddr;
    logic [CELL_W-1:0] w_wdata;
    logic [AW-1:0]     w_raddr;
    logic [CELL_W-1:0] w_rdata;

    // Cursor step values
    logic [CW-1:0]     w_cur_inc, w_cur_dec;
    logic [COLW-1:0]   w_col_inc, w_col_dec;
    logic [TW-1:0]     w_tph_inc, w_tph_dec;
    logic [TW:0]       w_rph_sum, w_rph_dif, w_rph_wrap;
    logic [TW-1:0]     w_rph_up, w_rph_dn;
    logic [TW-1:0]     w_rph_inc, w_rph_dec;

    // Request decode and completion
    logic              w_in_fire;
    logic              w_out_free;
    logic [31:0]       w_idx_ext;
    logic              w_idx_in;
    logic              w_fin;
    logic [BYTE_W-1:0] w_fin_char, w_fin_attr;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_cell_char = r_out_char;
    assign o_cell_attr = r_out_attr;
    assign o_cursor_pos = r_out_cursor;

    assign w_in_fire  = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_idx_ext  = 32'(i_cell_index);
    assign w_idx_in   = (w_idx_ext < 32'(CELLS));

    // Step the cursor forward or back one cell, keeping column and phases
    always_comb begin
        w_cur_inc = r_cursor + CW'(1);
        w_cur_dec = r_cursor - CW'(1);
        w_col_inc = (r_col == COLW'(COLUMNS - 1)) ? '0 : r_col + COLW'(1);
        w_col_dec = (r_col == '0) ? COLW'(COLUMNS - 1) : r_col - COLW'(1);
        w_tph_inc = (r_tph == TW'(TAB_STOP - 1)) ? '0 : r_tph + TW'(1);
        w_tph_dec = (r_tph == '0) ? TW'(TAB_STOP - 1) : r_tph - TW'(1);
        w_rph_sum = {1'b0, r_rph} + (TW+1)'(CMT);
        w_rph_dif = w_rph_sum - (TW+1)'(TAB_STOP);
        w_rph_up  = (w_rph_sum >= (TW+1)'(TAB_STOP)) ? w_rph_dif[TW-1:0]
                                                      : w_rph_sum[TW-1:0];
        w_rph_wrap = {1'b0, r_rph} + (TW+1)'(TAB_STOP - CMT);
        w_rph_dn  = (r_rph >= TW'(CMT)) ? r_rph - TW'(CMT) : w_rph_wrap[TW-1:0];
        w_rph_inc = (r_col == COLW'(COLUMNS - 1)) ? w_rph_up : r_rph;
        w_rph_dec = (r_col == '0) ? w_rph_dn : r_rph;
    end

    // Sequence clearing, scrolling, cursor moves and reads
    always_comb begin
        n_state      = r_state;
        n_addr       = r_addr;
        n_cursor     = r_cursor;
        n_col        = r_col;
        n_rph        = r_rph;
        n_tph        = r_tph;
        n_char       = r_char;
        n_idx_ok     = r_idx_ok;
        n_res_char   = r_res_char;
        n_res_attr   = r_res_attr;
        n_out_valid  = r_out_valid;
        n_out_char   = r_out_char;
        n_out_attr   = r_out_attr;
        n_out_cursor = r_out_cursor;
        w_we         = 1'b0;
        w_waddr      = r_addr;
        w_wdata      = '0;
        w_raddr      = r_addr + AW'(COLUMNS);
        w_fin        = 1'b0;
        w_fin_char   = '0;
        w_fin_attr   = '0;

        // drop the result once its transfer completes
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_addr;
                w_wdata = '0;
                if (r_addr == AW'(CELLS - 1)) begin
                    n_addr  = '0;
                    n_state = S_IDLE;
                end else begin
                    n_addr = r_addr + AW'(1);
                end
            end
            S_IDLE: begin
                w_raddr = w_idx_in ? w_idx_ext[AW-1:0] : '0;
                if (w_in_fire) begin
                    n_char   = i_char_code;
                    n_idx_ok = w_idx_in;
                    n_addr   = '0;
                    if (i_req_type == REQ_READ) begin
                        n_state = S_RDATA;
                    end else if (r_cursor == CW'(CELLS)) begin
                        n_state = S_MOVE;
                    end else begin
                        n_state = S_PUT;
                    end
                end
            end
            S_RDATA: begin
                w_fin      = 1'b1;
                w_fin_char = r_idx_ok ? w_rdata[BYTE_W-1:0] : '0;
                w_fin_attr = r_idx_ok ? w_rdata[CELL_W-1:BYTE_W] : '0;
            end
            S_MOVE: begin
                // read one row below, write the cell read last cycle
                w_raddr = r_addr + AW'(COLUMNS);
                w_waddr = r_addr - AW'(1);
                w_wdata = w_rdata;
                w_we    = (r_addr != '0);
                if (r_addr == AW'(CELLS - COLUMNS)) begin
                    n_state = S_BLANK;
                end else begin
                    n_addr = r_addr + AW'(1);
                end
            end
            S_BLANK: begin
                w_we    = 1'b1;
                w_waddr = r_addr;
                w_wdata = {r_text_color, CH_SPACE};
                if (r_addr == AW'(CELLS - 1)) begin
                    n_cursor = CW'(CELLS - COLUMNS);
                    n_col    = '0;
                    n_rph    = TW'(RPH_LAST);
                    n_tph    = TW'(RPH_LAST);
                    n_state  = S_PUT;
                end else begin
                    n_addr = r_addr + AW'(1);
                end
            end
            S_PUT: begin
                case (r_char)
                    CH_LF: begin
                        n_cursor = r_cursor + CW'(COLUMNS) - CW'(r_col);
                        n_col    = '0;
                        n_rph    = w_rph_up;
                        n_tph    = w_rph_up;
                        w_fin    = 1'b1;
                    end
                    CH_CR: begin
                        n_cursor = r_cursor - CW'(r_col);
                        n_col    = '0;
                        n_tph    = r_rph;
                        w_fin    = 1'b1;
                    end
                    CH_BS: begin
                        if (r_cursor != '0) begin
                            n_cursor = w_cur_dec;
                            n_col    = w_col_dec;
                            n_rph    = w_rph_dec;
                            n_tph    = w_tph_dec;
                        end
                        w_fin = 1'b1;
                    end
                    CH_TAB: begin
                        n_state = S_TAB;
                    end
                    default: begin
                        w_we     = 1'b1;
                        w_waddr  = r_cursor[AW-1:0];
                        w_wdata  = {r_text_color, r_char};
                        n_cursor = w_cur_inc;
                        n_col    = w_col_inc;
                        n_rph    = w_rph_inc;
                        n_tph    = w_tph_inc;
                        w_fin    = 1'b1;
                    end
                endcase
            end
            S_TAB: begin
                // advance one cell until a stop or the end of the screen
                n_cursor = w_cur_inc;
                n_col    = w_col_inc;
                n_rph    = w_rph_inc;
                n_tph    = w_tph_inc;
                if (w_tph_inc == '0 || w_cur_inc == CW'(CELLS)) begin
                    w_fin = 1'b1;
                end
            end
            S_OUT: begin
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_char   = r_res_char;
                    n_out_attr   = r_res_attr;
                    n_out_cursor = IDX_W'(n_cursor);
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // hand the result to the output register, or hold it; report the
        // cursor as it stands after this cycle's move
        if (w_fin) begin
            if (w_out_free) begin
                n_out_valid  = 1'b1;
                n_out_char   = w_fin_char;
                n_out_attr   = w_fin_attr;
                n_out_cursor = IDX_W'(n_cursor);
                n_state      = S_IDLE;
            end else begin
                n_res_char = w_fin_char;
                n_res_attr = w_fin_attr;
                n_state    = S_OUT;
            end
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_addr       <= '0;
            r_cursor     <= '0;
            r_col        <= '0;
            r_rph        <= '0;
            r_tph        <= '0;
            r_out_valid  <= 1'b0;
            r_text_color <= COLOR_RESET;
        end else begin
            r_state     <= n_state;
            r_addr      <= n_addr;
            r_cursor    <= n_cursor;
            r_col       <= n_col;
            r_rph       <= n_rph;
            r_tph       <= n_tph;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_text_color <= i_cfg_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_char       <= n_char;
        r_idx_ok     <= n_idx_ok;
        r_res_char   <= n_res_char;
        r_res_attr   <= n_res_attr;
        r_out_char   <= n_out_char;
        r_out_attr   <= n_out_attr;
        r_out_cursor <= n_out_cursor;
    end

    tcw_screen_ram #(
        .DEPTH (CELLS),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Checks
    `TCW_ASSERT_IMPL(a_no_accept_in_clear, i_clk, i_rst_n, r_state == S_CLEAR, !o_in_ready)
    `TCW_ASSERT_IMPL(a_row_start_phase, i_clk, i_rst_n, r_col == '0, r_tph == r_rph)
    `TCW_ASSERT_IMPL(a_cursor_bound, i_clk, i_rst_n, r_cursor >= CW'(CELLS), r_cursor == CW'(CELLS) && r_col == '0)
    `TCW_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready)

endmodule

// ===== src/tcw_screen_ram.sv =====
// ----------------------------------------------------------------------------
// tcw_screen_ram
// Screen cell memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcw_screen_ram #(
    parameter int DEPTH = tcw_pkg::COLUMNS_DEF * tcw_pkg::ROWS_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [AW-1:0]             i_waddr,
    input  logic [tcw_pkg::CELL_W-1:0] i_wdata,
    input  logic [AW-1:0]             i_raddr,
    output logic [tcw_pkg::CELL_W-1:0] o_rdata
);
    import tcw_pkg::*;

    logic [CELL_W-1:0] r_mem [DEPTH];
    logic [CELL_W-1:0] r_rdata;

    // Write one cell
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read one cell, data valid the next cycle
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
